// ===== hdl/sled_pkg.sv =====
// Shared types, codes and character-class functions for the escape decoder.
`default_nettype none

package sled_pkg;

    localparam int unsigned CP_W  = 21;
    localparam int unsigned ERR_W = 3;

    localparam logic [CP_W-1:0] MAX_SCALAR = 21'h10FFFF;
    localparam logic [CP_W-1:0] SURR_LO    = 21'h00D800;
    localparam logic [CP_W-1:0] SURR_HI    = 21'h00DFFF;
    localparam logic [CP_W-1:0] HEX_RADIX  = 21'h000010;

    // Error codes carried on error_code
    localparam logic [ERR_W-1:0] ERR_NONE       = 3'd0;
    localparam logic [ERR_W-1:0] ERR_BAD_HEX    = 3'd1;
    localparam logic [ERR_W-1:0] ERR_BAD_SCALAR = 3'd2;
    localparam logic [ERR_W-1:0] ERR_UNKNOWN    = 3'd3;
    localparam logic [ERR_W-1:0] ERR_NO_LINE    = 3'd4;
    localparam logic [ERR_W-1:0] ERR_UNFINISHED = 3'd5;

    typedef enum logic [2:0] {
        MODE_NORMAL   = 3'd0,
        MODE_BSLASH   = 3'd1,
        MODE_HEX      = 3'd2,
        MODE_CONT_WS1 = 3'd3,
        MODE_CONT_LE  = 3'd4,
        MODE_CONT_WS2 = 3'd5
    } t_esc_mode;

    typedef struct packed {
        t_esc_mode        mode;
        logic [CP_W-1:0]  acc;
        logic             seen;
        logic             ovf;
        logic [ERR_W-1:0] err;
    } t_state;

    typedef struct packed {
        logic             char_present;
        logic [CP_W-1:0]  decoded_char;
        logic [ERR_W-1:0] error_code;
        logic             end_of_literal;
    } t_result;

    // Tab or a Zs space
    function automatic logic is_ws(input logic [CP_W-1:0] c);
        return (c == 21'h09) || (c == 21'h20) || (c == 21'hA0) || (c == 21'h1680)
            || ((c >= 21'h2000) && (c <= 21'h200A))
            || (c == 21'h202F) || (c == 21'h205F) || (c == 21'h3000);
    endfunction

    // CR, LF, NEL or line separator
    function automatic logic is_line_end(input logic [CP_W-1:0] c);
        return (c == 21'h0D) || (c == 21'h0A) || (c == 21'h85) || (c == 21'h2028);
    endfunction

    // {valid, digit value}
    function automatic logic [4:0] hex_val(input logic [CP_W-1:0] c);
        logic [CP_W-1:0] t;
        t = '0;
        if ((c >= 21'h30) && (c <= 21'h39)) begin
            t = c - 21'h30;
            return {1'b1, t[3:0]};
        end
        if ((c >= 21'h61) && (c <= 21'h66)) begin
            t = c - 21'h57;
            return {1'b1, t[3:0]};
        end
        if ((c >= 21'h41) && (c <= 21'h46)) begin
            t = c - 21'h37;
            return {1'b1, t[3:0]};
        end
        return 5'b0_0000;
    endfunction

endpackage

`default_nettype wire

// ===== hdl/sled_if.sv =====
// Valid/ready channel interfaces for code points in and decoded results out.
`default_nettype none

interface sled_in_if;
    import sled_pkg::*;
    logic            valid;
    logic            ready;
    logic [CP_W-1:0] code_point;
    logic            is_last;

    modport source (output valid, output code_point, output is_last, input ready);
    modport sink   (input valid, input code_point, input is_last, output ready);
endinterface

interface sled_out_if;
    import sled_pkg::*;
    logic             valid;
    logic             ready;
    logic             char_present;
    logic [CP_W-1:0]  decoded_char;
    logic [ERR_W-1:0] error_code;
    logic             end_of_literal;

    modport source (output valid, output char_present, output decoded_char,
                    output error_code, output end_of_literal, input ready);
    modport sink   (input valid, input char_present, input decoded_char,
                    input error_code, input end_of_literal, output ready);
endinterface

`default_nettype wire

// ===== hdl/sled_step.sv =====
// Next-state and result logic for one code point of the literal body.
`default_nettype none

module sled_step
    import sled_pkg::*;
(
    input  wire t_state          i_state,
    input  wire logic [CP_W-1:0] i_code_point,
    input  wire logic            i_is_last,
    output t_state               o_state,
    output t_result              o_result
);

    t_state          n;
    logic            emit;
    logic [CP_W-1:0] outc;
    logic [4:0]      hv;
    logic [CP_W+3:0] nv;
    logic            ws;
    logic            le;

    assign hv = hex_val(i_code_point);
    assign ws = is_ws(i_code_point);
    assign le = is_line_end(i_code_point);
    // shift-add of the next hex digit, four bits of headroom
    assign nv = {i_state.acc, 4'h0} + {{CP_W{1'b0}}, hv[3:0]};

    always_comb begin
        n    = i_state;
        emit = 1'b0;
        outc = '0;

        if (i_state.err == ERR_NONE) begin
            case (i_state.mode)
                MODE_BSLASH: begin
                    n.mode = MODE_NORMAL;
                    emit   = 1'b1;
                    case (i_code_point)
                        21'h61:  outc = 21'h07;
                        21'h62:  outc = 21'h08;
                        21'h74:  outc = 21'h09;
                        21'h6E:  outc = 21'h0A;
                        21'h76:  outc = 21'h0B;
                        21'h66:  outc = 21'h0C;
                        21'h72:  outc = 21'h0D;
                        21'h22:  outc = 21'h22;
                        21'h5C:  outc = 21'h5C;
                        21'h78, 21'h58: begin
                            emit   = 1'b0;
                            n.mode = MODE_HEX;
                            n.acc  = '0;
                            n.seen = 1'b0;
                            n.ovf  = 1'b0;
                        end
                        default: begin
                            emit = 1'b0;
                            if (ws) begin
                                n.mode = MODE_CONT_WS1;
                            end else if (le) begin
                                n.mode = MODE_CONT_LE;
                            end else begin
                                n.err = ERR_UNKNOWN;
                            end
                        end
                    endcase
                end
                MODE_HEX: begin
                    if (hv[4]) begin
                        // saturate once the value leaves the scalar range
                        if (i_state.ovf || (nv > {4'h0, MAX_SCALAR})) begin
                            n.ovf = 1'b1;
                            n.acc = MAX_SCALAR;
                        end else begin
                            n.acc = nv[CP_W-1:0];
                        end
                        n.seen = 1'b1;
                    end else if ((i_code_point == 21'h3B) && i_state.seen) begin
                        if (i_state.ovf ||
                            ((i_state.acc >= SURR_LO) && (i_state.acc <= SURR_HI))) begin
                            n.err = ERR_BAD_SCALAR;
                        end else begin
                            emit   = 1'b1;
                            outc   = i_state.acc;
                            n.mode = MODE_NORMAL;
                        end
                    end else begin
                        n.err = ERR_BAD_HEX;
                    end
                end
                MODE_CONT_WS1: begin
                    if (le) begin
                        n.mode = MODE_CONT_LE;
                    end else if (!ws) begin
                        n.err = ERR_NO_LINE;
                    end
                end
                MODE_CONT_LE, MODE_CONT_WS2: begin
                    if (ws) begin
                        n.mode = MODE_CONT_WS2;
                    end else if (le && (i_state.mode == MODE_CONT_LE)) begin
                        n.mode = MODE_CONT_LE;
                    end else if (i_code_point == 21'h5C) begin
                        n.mode = MODE_BSLASH;
                    end else begin
                        n.mode = MODE_NORMAL;
                        emit   = 1'b1;
                        outc   = i_code_point;
                    end
                end
                default: begin
                    if (i_code_point == 21'h5C) begin
                        n.mode = MODE_BSLASH;
                    end else begin
                        n.mode = MODE_NORMAL;
                        emit   = 1'b1;
                        outc   = i_code_point;
                    end
                end
            endcase

            // literal closes inside an escape
            if (i_is_last && (n.err == ERR_NONE)) begin
                if ((n.mode == MODE_BSLASH) || (n.mode == MODE_HEX)) begin
                    n.err = ERR_UNFINISHED;
                end else if (n.mode == MODE_CONT_WS1) begin
                    n.err = ERR_NO_LINE;
                end
            end
        end

        if (n.err != ERR_NONE) begin
            emit = 1'b0;
            outc = '0;
        end

        o_result.char_present   = emit;
        o_result.decoded_char   = outc;
        o_result.error_code     = n.err;
        o_result.end_of_literal = i_is_last;

        // fresh state for the next literal
        if (i_is_last) begin
            n.mode = MODE_NORMAL;
            n.acc  = '0;
            n.seen = 1'b0;
            n.ovf  = 1'b0;
            n.err  = ERR_NONE;
        end
        o_state = n;
    end

endmodule

`default_nettype wire

// ===== hdl/string_literal_escape_decoder_top.sv =====
// Top level of the string literal escape decoder.
// Usage:
//   i_in carries one code point of a string literal body per beat, with
//   is_last set on the final body character; quotes are not sent.
//   o_out returns exactly one beat per input beat: the decoded character
//   when char_present is set, the sticky error code, and end_of_literal.
// Timing: the result beat is registered, valid the cycle after its input.
// Throughput: one beat per cycle unless stalled (see Stall); escape state
//   and output register are updated in a single pass per accepted beat.
// Stall: while a result waits in the output register and o_out.ready is low,
//   i_in.ready is low; taking the result frees the register in the same
//   cycle for the next beat.
// Reset: i_rst_n low clears the escape state and the sticky error and
//   empties the output register. After each last beat the state returns to
//   its reset value for the next literal.
`default_nettype none

module string_literal_escape_decoder_top
    import sled_pkg::*;
(
    input  wire logic      i_clk,
    input  wire logic      i_rst_n,
    sled_in_if.sink        i_in,
    sled_out_if.source     o_out
);

    t_state  r_state;
    t_state  n_state;
    t_result r_result;
    t_result n_result;
    logic    r_valid;
    logic    w_in_fire;

    assign i_in.ready = !r_valid || o_out.ready;
    assign w_in_fire  = i_in.valid && i_in.ready;

    // per-beat decode
    sled_step u_step (
        .i_state      (r_state),
        .i_code_point (i_in.code_point),
        .i_is_last    (i_in.is_last),
        .o_state      (n_state),
        .o_result     (n_result)
    );

    // escape state and output valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state.mode <= MODE_NORMAL;
            r_state.acc  <= '0;
            r_state.seen <= 1'b0;
            r_state.ovf  <= 1'b0;
            r_state.err  <= ERR_NONE;
            r_valid      <= 1'b0;
        end else begin
            if (w_in_fire) begin
                r_state <= n_state;
            end
            if (w_in_fire) begin
                r_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_valid <= 1'b0;
            end
        end
    end

    // result payload
    always_ff @(posedge i_clk) begin
        if (w_in_fire) begin
            r_result <= n_result;
        end
    end

    assign o_out.valid          = r_valid;
    assign o_out.char_present   = r_result.char_present;
    assign o_out.decoded_char   = r_result.decoded_char;
    assign o_out.error_code     = r_result.error_code;
    assign o_out.end_of_literal = r_result.end_of_literal;

    // a last beat always leaves a clean state behind
    a_last_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_in_fire && i_in.is_last) |=>
            ((r_state.mode == MODE_NORMAL) && (r_state.err == ERR_NONE) && !r_state.ovf))
        else $error("state not cleared after last beat");

    // no character is delivered alongside an error
    a_char_no_err: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_valid && r_result.char_present) |-> (r_result.error_code == ERR_NONE))
        else $error("character emitted with error pending");

    // saturated accumulator holds the maximum scalar
    a_ovf_sat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state.ovf |-> (r_state.acc == MAX_SCALAR))
        else $error("hex overflow without saturation");

    // a stored error stays until the literal ends
    a_err_sticky: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_in_fire && (r_state.err != ERR_NONE) && !i_in.is_last) |=>
            (r_state.err == $past(r_state.err)))
        else $error("sticky error lost inside literal");

endmodule

`default_nettype wire
